// File: src/k_way_sorted_merge_core_assert.svh
// Assertion macros for the k-way merge RTL.
// Stand-alone header; kwm_back, which checks its own logic, includes it.
`ifndef K_WAY_SORTED_MERGE_CORE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define KWM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kwm: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define KWM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kwm: next-cycle check failed");

`endif

// File: src/kwm_pkg.sv
// Types and fixed constants of the k-way merge core.
// No dependencies; imported by all modules but kwm_ram.
package kwm_pkg;

    localparam int IDX_W = 3;
    localparam int VAL_W = 32;
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // One input item as it arrives on the input channel.
    typedef struct packed {
        logic [IDX_W-1:0]        list_index;
        logic signed [VAL_W-1:0] element_value;
        logic                    list_end;
        logic                    empty_list;
    } t_in_item;

    // One result item on the output channel.
    typedef struct packed {
        logic signed [VAL_W-1:0] merged_value;
        logic [IDX_W-1:0]        source_list;
        logic                    last;
        logic                    dropped;
    } t_out_item;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        t_in_item item;
        logic     inactive;
    } t_cmd;

    // Occupancy flags of the command queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } t_back_state;

endpackage

// File: src/kwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/kwm_front.sv
// Front end of the k-way merge: configuration register, input acceptance and
// classification of each item against the active list count. Uses kwm_pkg.
module kwm_front import kwm_pkg::*; #(
    parameter int LANES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  t_in_item                    i_in_data,
    input  logic                        i_q_full,
    output logic                        o_push,
    output t_cmd                        o_cmd,
    output logic [$clog2(LANES+1)-1:0]  o_act
);

    localparam int CNT_W = $clog2(LANES + 1);
    localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic [CFG_W-1:0] r_active_lists;
    logic [EXT_W-1:0] w_cfg_ext;
    logic [CNT_W-1:0] w_act;
    logic             w_inactive;

    // Config register; user writes only while the block is idle, unenforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_lists <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_active_lists <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Clamp the register to the range 1 .. LANES.
    always_comb begin
        w_cfg_ext = EXT_W'(r_active_lists);
        if (w_cfg_ext == '0) begin
            w_act = CNT_W'(1);
        end else if (w_cfg_ext > EXT_W'(LANES)) begin
            w_act = CNT_W'(LANES);
        end else begin
            w_act = CNT_W'(w_cfg_ext);
        end
    end

    // A list number at or beyond the active count is rejected outright.
    assign w_inactive = CMP_W'(i_in_data.list_index) >= CMP_W'(w_act);

    // Accept whenever the command queue has room.
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_cmd      = '{item: i_in_data, inactive: w_inactive};
    assign o_act      = w_act;

endmodule

// File: src/kwm_queue.sv
// Two-entry command queue between the front and back ends of the k-way merge.
// Uses kwm_pkg for the command and status types.
module kwm_queue import kwm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    // Occupancy count follows the push and pop transfers.
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.full  = r_count == 2'd2;
    assign o_status.empty = r_count == 2'd0;

endmodule

// File: src/kwm_back.sv
// Back end of the k-way merge: lane bookkeeping, lane store, head scan and
// result register. Uses kwm_pkg, kwm_ram and the assertion macro header.
`include "k_way_sorted_merge_core_assert.svh"

module kwm_back import kwm_pkg::*; #(
    parameter int LANES      = 8,
    parameter int LANE_DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [$clog2(LANES+1)-1:0]  i_act,
    input  t_cmd                        i_cmd,
    input  logic                        i_q_empty,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output t_out_item                   o_out_data
);

    localparam int CNT_W  = $clog2(LANES + 1);
    localparam int LANE_W = $clog2(LANES);
    localparam int POS_W  = $clog2(LANE_DEPTH);
    localparam int FILL_W = $clog2(LANE_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int ADDR_W = LANE_W + POS_W;
    localparam int RAM_D  = LANES * (2 ** POS_W);

    t_back_state r_state, n_state;

    logic [FILL_W-1:0] r_fill [LANES];
    logic [FILL_W-1:0] n_fill [LANES];
    logic [POS_W-1:0]  r_rpos [LANES];
    logic [POS_W-1:0]  n_rpos [LANES];
    logic              r_fin  [LANES];
    logic              n_fin  [LANES];

    logic [CNT_W-1:0]        r_scan_k, n_scan_k;
    logic                    r_cmp_vld, n_cmp_vld;
    logic [LANE_W-1:0]       r_cmp_lane, n_cmp_lane;
    logic                    r_best_any, n_best_any;
    logic [LANE_W-1:0]       r_best_lane, n_best_lane;
    logic signed [VAL_W-1:0] r_best_val, n_best_val;
    logic [IDX_W-1:0]        r_drop_lane, n_drop_lane;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    logic              w_ready;
    logic              w_any;
    logic              w_done;
    logic              w_fill_ok;
    logic              w_all_clear;
    logic [LANE_W-1:0] w_lane;
    logic              w_drop;
    logic [SUM_W-1:0]  w_sum;
    logic [POS_W-1:0]  w_wp;
    logic              w_scan_in;
    logic [LANE_W-1:0] w_scan_lane;
    logic              w_take;
    logic              w_out_free;
    logic              w_load_last;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [VAL_W-1:0]  ram_rd_data;

    // Lane store: LANES queues of LANE_DEPTH elements each.
    kwm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_D)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_cmd.item.element_value),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Merge readiness and done flags on active lanes; assert checks on all lanes.
    always_comb begin
        w_ready     = 1'b1;
        w_any       = 1'b0;
        w_done      = 1'b1;
        w_fill_ok   = 1'b1;
        w_all_clear = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            if (CNT_W'(i) < i_act) begin
                if (r_fill[i] == '0) begin
                    if (!r_fin[i]) begin
                        w_ready = 1'b0;
                    end
                end else begin
                    w_any = 1'b1;
                end
                // After the best head leaves, every active lane must be empty and finished.
                if (LANE_W'(i) == r_best_lane) begin
                    if (r_fill[i] != FILL_W'(1) || !r_fin[i]) begin
                        w_done = 1'b0;
                    end
                end else if (r_fill[i] != '0 || !r_fin[i]) begin
                    w_done = 1'b0;
                end
            end
            if (r_fill[i] > FILL_W'(LANE_DEPTH)) begin
                w_fill_ok = 1'b0;
            end
            if (r_fill[i] != '0 || r_fin[i]) begin
                w_all_clear = 1'b0;
            end
        end
    end

    // Classification of the command at the head of the queue.
    always_comb begin
        w_lane = i_cmd.inactive ? '0 : LANE_W'(i_cmd.item.list_index);
        w_drop = i_cmd.inactive || r_fin[w_lane] ||
                 (!i_cmd.item.empty_list && r_fill[w_lane] == FILL_W'(LANE_DEPTH));
        w_sum  = SUM_W'(r_rpos[w_lane]) + SUM_W'(r_fill[w_lane]);
        if (w_sum >= SUM_W'(LANE_DEPTH)) begin
            w_wp = POS_W'(w_sum - SUM_W'(LANE_DEPTH));
        end else begin
            w_wp = POS_W'(w_sum);
        end
    end

    // Head scan: one lane read issued per cycle, compared in the cycle after it.
    always_comb begin
        w_scan_in   = r_scan_k < i_act;
        w_scan_lane = w_scan_in ? r_scan_k[LANE_W-1:0] : '0;
        w_take      = r_cmp_vld && (!r_best_any || $signed(ram_rd_data) < r_best_val);
        ram_rd_addr = {w_scan_lane, r_rpos[w_scan_lane]};
        ram_wr_addr = {w_lane, w_wp};
    end

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load_last = (r_state == ST_EMIT) && w_out_free && w_done;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = w_drop ? ST_DROP : ST_CHECK;
                end
            end
            ST_DROP: begin
                if (w_out_free) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!w_ready || !w_any) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan_k == i_act) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = w_done ? ST_IDLE : ST_CHECK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and bookkeeping updates for each state.
    always_comb begin
        n_fill      = r_fill;
        n_rpos      = r_rpos;
        n_fin       = r_fin;
        n_scan_k    = r_scan_k;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_lane  = r_cmp_lane;
        n_best_any  = r_best_any;
        n_best_lane = r_best_lane;
        n_best_val  = r_best_val;
        n_drop_lane = r_drop_lane;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_pop       = 1'b0;
        ram_wr_en   = 1'b0;

        // The result register empties on an output transfer.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (w_drop) begin
                        n_drop_lane = i_cmd.item.list_index;
                    end else if (i_cmd.item.empty_list) begin
                        n_fin[w_lane] = 1'b1;
                    end else begin
                        ram_wr_en      = 1'b1;
                        n_fill[w_lane] = r_fill[w_lane] + FILL_W'(1);
                        if (i_cmd.item.list_end) begin
                            n_fin[w_lane] = 1'b1;
                        end
                    end
                end
            end
            ST_DROP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{merged_value: '0, source_list: r_drop_lane,
                              last: 1'b0, dropped: 1'b1};
                end
            end
            ST_CHECK: begin
                // Every active list finished without elements: start afresh.
                if (w_ready && !w_any) begin
                    for (int i = 0; i < LANES; i++) begin
                        n_fill[i] = '0;
                        n_rpos[i] = '0;
                        n_fin[i]  = 1'b0;
                    end
                end
                n_scan_k   = '0;
                n_cmp_vld  = 1'b0;
                n_best_any = 1'b0;
            end
            ST_SCAN: begin
                if (w_scan_in) begin
                    n_scan_k = r_scan_k + CNT_W'(1);
                end
                n_cmp_vld  = w_scan_in && (r_fill[w_scan_lane] != '0);
                n_cmp_lane = w_scan_lane;
                // Strict compare keeps the lower list on equal values.
                if (w_take) begin
                    n_best_any  = 1'b1;
                    n_best_lane = r_cmp_lane;
                    n_best_val  = $signed(ram_rd_data);
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{merged_value: r_best_val, source_list: IDX_W'(r_best_lane),
                              last: w_done, dropped: 1'b0};
                    if (w_done) begin
                        for (int i = 0; i < LANES; i++) begin
                            n_fill[i] = '0;
                            n_rpos[i] = '0;
                            n_fin[i]  = 1'b0;
                        end
                    end else begin
                        n_fill[r_best_lane] = r_fill[r_best_lane] - FILL_W'(1);
                        if (r_rpos[r_best_lane] == POS_W'(LANE_DEPTH - 1)) begin
                            n_rpos[r_best_lane] = '0;
                        end else begin
                            n_rpos[r_best_lane] = r_rpos[r_best_lane] + POS_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_k    <= '0;
            r_cmp_vld   <= 1'b0;
            r_best_any  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_fill[i] <= '0;
                r_rpos[i] <= '0;
                r_fin[i]  <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_scan_k    <= n_scan_k;
            r_cmp_vld   <= n_cmp_vld;
            r_best_any  <= n_best_any;
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
            r_rpos      <= n_rpos;
            r_fin       <= n_fin;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmp_lane  <= n_cmp_lane;
        r_best_lane <= n_best_lane;
        r_best_val  <= n_best_val;
        r_drop_lane <= n_drop_lane;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // No lane queue ever holds more than its depth.
    `KWM_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, w_fill_ok)
    // A result only appears from the drop or emit state.
    `KWM_ASSERT_IMPL(a_load_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_DROP || $past(r_state) == ST_EMIT)
    // The final element of a merge leaves every lane cleared.
    `KWM_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_load_last, w_all_clear)
    // Emission always has a head to send.
    `KWM_ASSERT_IMPL(a_emit_has_head, i_clk, i_rst_n, r_state == ST_EMIT, r_best_any)

endmodule

// File: src/k_way_sorted_merge_core.sv
// k_way_sorted_merge_core: top level; uses kwm_pkg, kwm_front, kwm_queue, kwm_back.
// Flow: an accepted item enters the command queue; the back end pops it while idle and
// stores its element in the lane store. Each merged result then takes a check, a scan of
// the N active lane heads on the store's one read port plus a final compare, and an emit.
// The back end takes one queued item at a time, adding a drop result where one is due.
// Reset: synchronous, active low; clears queue, lane counts and flags, active_lists to 8.
module k_way_sorted_merge_core import kwm_pkg::*; #(
    parameter int LANES      = 8,
    parameter int LANE_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    localparam int CNT_W = $clog2(LANES + 1);

    logic             push;
    logic             pop;
    t_cmd             front_cmd;
    t_cmd             head_cmd;
    t_q_status        q_status;
    logic [CNT_W-1:0] act;

    // Input acceptance, configuration and classification.
    kwm_front #(
        .LANES (LANES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_status.full),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .o_act       (act)
    );

    // Short command queue decoupling the two halves.
    kwm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    // Lane store, merge sequencing and result register.
    kwm_back #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_act       (act),
        .i_cmd       (head_cmd),
        .i_q_empty   (q_status.empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/tb_k_way_sorted_merge_core.sv
// Self-checking testbench for k_way_sorted_merge_core: directed and random merges.
// Depends on kwm_pkg and the core RTL; the expected stream comes from a merge predictor kept here.
module tb_k_way_sorted_merge_core import kwm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES         = 8;
    localparam int LANE_DEPTH    = 8;
    localparam int MAX_OUT       = 64;
    localparam int SETTLE_CYCLES = 4 * LANES + 16;
    localparam int ITEMS_PER_PHASE = 76;

    // Value styles for generated lists.
    typedef enum int {
        VAL_TIES,
        VAL_WIDE,
        VAL_FROM_MIN
    } t_val_style;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    t_in_item         i_in_data   = '0;
    logic             i_out_stall = 1'b0;
    logic             o_cfg_ready;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_item        o_out_data;

    // Idling controls: send_idle_pct for the sender, stall_pct for the result checker.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Counters for the summary and the verdict.
    int mismatch_count = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int drops_expected = 0;
    int merges_closed  = 0;
    int cfg_writes     = 0;

    // Predictor state: one queue per lane, its counters and the register.
    logic signed [VAL_W-1:0] lane_mem [LANES][LANE_DEPTH];
    int                      head_pos [LANES];
    int                      held     [LANES];
    bit                      lane_done[LANES];
    logic [CFG_W-1:0]        active_raw = CFG_RESET;
    t_out_item               expected_merge_q[$];

    k_way_sorted_merge_core #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int lanes_in_use();
        if (active_raw == 0) return 1;
        if (active_raw > LANES) return LANES;
        return int'(active_raw);
    endfunction

    // Clearing the merge state frees every lane, active or not.
    task automatic clear_merge_state();
        int i;
        for (i = 0; i < LANES; i++) begin
            head_pos[i]  = 0;
            held[i]      = 0;
            lane_done[i] = 1'b0;
        end
        merges_closed++;
    endtask

    function automatic bit merge_open();
        int i;
        for (i = 0; i < LANES; i++)
            if (held[i] != 0 || lane_done[i]) return 1'b1;
        return 1'b0;
    endfunction

    // Applies one accepted input transfer and queues the results it causes.
    task automatic predict_merge_step(input t_in_item it);
        int act, lane, wr, best, produced, i;
        bit all_ready, any_held, done;
        logic signed [VAL_W-1:0] best_val, head;
        t_out_item res;
        act      = lanes_in_use();
        lane     = int'(it.list_index);
        produced = 0;
        if (lane >= act || lane_done[lane] ||
            (!it.empty_list && held[lane] >= LANE_DEPTH)) begin
            res.merged_value = '0;
            res.source_list  = it.list_index;
            res.last         = 1'b0;
            res.dropped      = 1'b1;
            expected_merge_q = {expected_merge_q, res};
            drops_expected++;
            produced = 1;
        end else if (it.empty_list) begin
            lane_done[lane] = 1'b1;
        end else begin
            wr = (head_pos[lane] + held[lane]) % LANE_DEPTH;
            lane_mem[lane][wr] = it.element_value;
            held[lane]++;
            if (it.list_end) lane_done[lane] = 1'b1;
        end

        // Emit the smallest head while every active lane has a head or is done.
        forever begin
            all_ready = 1'b1;
            any_held  = 1'b0;
            best      = 0;
            best_val  = '0;
            for (i = 0; i < act; i++) begin
                if (held[i] == 0) begin
                    if (!lane_done[i]) all_ready = 1'b0;
                end else begin
                    head = lane_mem[i][head_pos[i]];
                    if (!any_held || head < best_val) begin
                        best     = i;
                        best_val = head;
                    end
                    any_held = 1'b1;
                end
            end
            if (!all_ready) break;
            if (!any_held) begin
                clear_merge_state();
                break;
            end
            if (produced >= MAX_OUT) break;
            head_pos[best] = (head_pos[best] + 1) % LANE_DEPTH;
            held[best]--;
            done = 1'b1;
            for (i = 0; i < act; i++)
                if (held[i] != 0 || !lane_done[i]) done = 1'b0;
            res.merged_value = best_val;
            res.source_list  = best[IDX_W-1:0];
            res.last         = done;
            res.dropped      = 1'b0;
            expected_merge_q = {expected_merge_q, res};
            produced++;
            if (done) begin
                clear_merge_state();
                break;
            end
        end
    endtask

    function automatic t_in_item make_item(input int lane, input logic signed [VAL_W-1:0] val,
                                           input bit is_end, input bit is_empty);
        t_in_item it;
        it.list_index    = lane[IDX_W-1:0];
        it.element_value = val;
        it.list_end      = is_end;
        it.empty_list    = is_empty;
        return it;
    endfunction

    // Sends one item; valid stays high afterwards unless the next call idles first.
    task automatic send_item(input t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_merge_step(it);
        items_sent++;
    endtask

    // Drains every expected result, then lets a lane scan that yields nothing finish.
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (expected_merge_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_active_lists(input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        active_raw = value;
        cfg_writes++;
    endtask

    function automatic logic signed [VAL_W-1:0] first_value(input t_val_style style);
        case (style)
            VAL_TIES: return int'($urandom_range(16)) - 8;
            VAL_FROM_MIN: return {1'b1, {(VAL_W-1){1'b0}}};
            default: return $urandom();
        endcase
    endfunction

    // Next element of a list: non-descending and saturating, unless the list is shuffled.
    function automatic logic signed [VAL_W-1:0] next_value(input logic signed [VAL_W-1:0] prev,
                                                           input t_val_style style,
                                                           input bit shuffled);
        longint v;
        if (shuffled) return $urandom();
        if (style == VAL_TIES)
            v = longint'(prev) + longint'($urandom_range(3));
        else
            v = longint'(prev) + longint'($urandom_range(32'h3FFF_FFFF) >> $urandom_range(31));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        return v[VAL_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(5))
            0: return 4'd0;
            1: return 4'd15;
            2: return 4'd8;
            3: return 4'd1;
            default: return CFG_W'($urandom_range(15));
        endcase
    endfunction

    // One well-formed merge with random content, a little noise, and a close-out.
    task automatic run_one_merge();
        t_in_item lane_items[LANES+1][$];
        int open_lanes[$];
        int act, i, k, len, kind, pick, noise;
        bit shuffled;
        t_val_style style;
        logic signed [VAL_W-1:0] val;
        act = lanes_in_use();
        for (i = 0; i < act; i++) begin
            kind     = $urandom_range(99);
            shuffled = ($urandom_range(9) == 0);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: style = VAL_TIES;
                9:             style = VAL_FROM_MIN;
                default:       style = VAL_WIDE;
            endcase
            val = first_value(style);
            if (kind < 10) begin
                lane_items[i] = {lane_items[i],
                                 make_item(i, $urandom(), 1'($urandom_range(1)), 1'b1)};
            end else if (kind < 20) begin
                // Some elements, then an empty mark while they may still be queued.
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) begin
                    lane_items[i] = {lane_items[i], make_item(i, val, 1'b0, 1'b0)};
                    val = next_value(val, style, shuffled);
                end
                lane_items[i] = {lane_items[i],
                                 make_item(i, $urandom(), 1'($urandom_range(1)), 1'b1)};
            end else if (kind < 25) begin
                // A full queue and one more, which is dropped if nothing drained.
                for (k = 0; k < LANE_DEPTH; k++) begin
                    lane_items[i] = {lane_items[i], make_item(i, val, 1'b0, 1'b0)};
                    val = next_value(val, style, shuffled);
                end
                lane_items[i] = {lane_items[i], make_item(i, val, 1'b1, 1'b0)};
            end else begin
                len = ($urandom_range(9) < 2) ? $urandom_range(5, LANE_DEPTH)
                                              : $urandom_range(1, 4);
                for (k = 0; k < len; k++) begin
                    lane_items[i] = {lane_items[i], make_item(i, val, k == len - 1, 1'b0)};
                    val = next_value(val, style, shuffled);
                end
            end
        end
        noise = ($urandom_range(99) < 40) ? $urandom_range(1, 3) : 0;
        for (k = 0; k < noise; k++)
            lane_items[LANES] = {lane_items[LANES],
                                 make_item($urandom_range(LANES - 1), $urandom(),
                                           1'($urandom_range(1)), 1'($urandom_range(1)))};

        // Interleave the lists at random, keeping each list in order.
        forever begin
            open_lanes.delete();
            for (i = 0; i <= LANES; i++)
                if (lane_items[i].size() != 0) open_lanes = {open_lanes, i};
            if (open_lanes.size() == 0) break;
            pick = open_lanes[$urandom_range(open_lanes.size() - 1)];
            send_item(lane_items[pick].pop_front());
        end

        // Finish any lane that noise or a drop left open so the merge closes.
        while (merge_open()) begin
            pick = -1;
            for (i = lanes_in_use() - 1; i >= 0; i--)
                if (!lane_done[i]) pick = i;
            if (pick < 0) break;
            send_item(make_item(pick, $urandom(), 1'b0, 1'b1));
        end
    endtask

    // Drops for inactive, finished and full lists, an early empty mark, and ties.
    task automatic test_drops_and_marks();
        wait_until_idle();
        write_active_lists(4'd2);
        send_item(make_item(2, 32'sd77, 1'b0, 1'b0));
        send_item(make_item(2, 32'sd0, 1'b0, 1'b1));
        send_item(make_item(0, 32'sh8000_0000, 1'b0, 1'b0));
        send_item(make_item(0, -32'sd5, 1'b0, 1'b0));
        send_item(make_item(0, 32'sd0, 1'b0, 1'b0));
        send_item(make_item(0, 32'sd0, 1'b0, 1'b0));
        send_item(make_item(0, 32'sd3, 1'b0, 1'b0));
        send_item(make_item(0, 32'sd7, 1'b0, 1'b0));
        send_item(make_item(0, 32'sd100, 1'b0, 1'b0));
        send_item(make_item(0, 32'sh7FFF_FFFF, 1'b0, 1'b0));
        send_item(make_item(0, 32'sd200, 1'b1, 1'b0));
        send_item(make_item(0, 32'sd0, 1'b0, 1'b1));
        send_item(make_item(0, 32'sd300, 1'b0, 1'b0));
        send_item(make_item(0, 32'sd0, 1'b1, 1'b1));
        send_item(make_item(1, 32'sd0, 1'b0, 1'b0));
        send_item(make_item(1, 32'sh7FFF_FFFF, 1'b1, 1'b0));
    endtask

    // Register value zero, a merge of empty lists only, and a single-list merge.
    task automatic test_register_range();
        wait_until_idle();
        write_active_lists(4'd0);
        send_item(make_item(0, 32'sh5555_AAAA, 1'b1, 1'b1));
        send_item(make_item(1, 32'sd9, 1'b1, 1'b0));
        send_item(make_item(0, -32'sd1, 1'b1, 1'b0));
    endtask

    // A lane made inactive mid-merge keeps its entry until the merge clears.
    task automatic test_stale_lanes();
        wait_until_idle();
        write_active_lists(4'd15);
        send_item(make_item(5, 32'sd9, 1'b0, 1'b0));
        wait_until_idle();
        write_active_lists(4'd2);
        send_item(make_item(0, 32'sd0, 1'b0, 1'b1));
        send_item(make_item(1, 32'sd4, 1'b1, 1'b0));
    endtask

    // Random merges under one idling pattern, with register changes between merges.
    task automatic test_random_merges(input int idle_pct, input int stall_p);
        int first;
        send_idle_pct = idle_pct;
        stall_pct     = stall_p;
        first         = items_sent;
        wait_until_idle();
        write_active_lists(pick_setting());
        while (items_sent - first < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 30) begin
                wait_until_idle();
                write_active_lists(pick_setting());
            end
            run_one_merge();
        end
    endtask

    // Output side: random stall and an in-order check of every result transfer.
    initial begin : result_checker
        t_out_item got, want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = o_out_data;
                results_seen++;
                if (expected_merge_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d list %0d last %0b drop %0b",
                                              got.merged_value, got.source_list, got.last,
                                              got.dropped));
                end else begin
                    want = expected_merge_q.pop_front();
                    if (got.merged_value !== want.merged_value)
                        report_mismatch($sformatf("merged_value %0d, expected %0d",
                                                  got.merged_value, want.merged_value));
                    if (got.source_list !== want.source_list)
                        report_mismatch($sformatf("source_list %0d, expected %0d",
                                                  got.source_list, want.source_list));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
                    if (got.dropped !== want.dropped)
                        report_mismatch($sformatf("dropped %0b, expected %0b",
                                                  got.dropped, want.dropped));
                end
            end
            i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Test sequence.
    initial begin
        clear_merge_state();
        merges_closed = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_drops_and_marks();
        test_register_range();
        test_stale_lanes();
        test_random_merges(0, 0);
        test_random_merges(49, 0);
        test_random_merges(0, 49);
        test_random_merges(13, 13);

        wait_until_idle();
        if (expected_merge_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_merge_q.size()));
        $display("Summary: %0d input transfers, %0d merges closed, %0d register writes;",
                 items_sent, merges_closed, cfg_writes);
        $display("Summary: %0d results checked, %0d of them drops.", results_seen, drops_expected);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/kwm_pkg.sv
src/kwm_ram.sv
src/kwm_front.sv
src/kwm_queue.sv
src/kwm_back.sv
src/k_way_sorted_merge_core.sv
tb/tb_k_way_sorted_merge_core.sv
